// ----- sv/fblm_pkg.sv -----
`timescale 1ns / 1ps

package fblm_pkg;

  localparam int unsigned    FBLM_LIST_DEPTH = 256;
  localparam logic [10:0]    FBLM_MAX_BLOCKS = 11'd1024;
  localparam int unsigned    FBLM_BLK_W      = 10;
  localparam int unsigned    FBLM_TOTAL_W    = 11;
  localparam int unsigned    FBLM_FCNT_W     = 9;
  localparam int unsigned    FBLM_IN_W       = 16;
  localparam int unsigned    FBLM_OUT_W      = 40;

  typedef enum logic [1:0] {
    CMD_RELEASE = 2'd0,
    CMD_OCCUPY  = 2'd1,
    CMD_EXTEND  = 2'd2,
    CMD_CHECK   = 2'd3
  } fblm_cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_BLOCK     = 3'd1,
    ST_FREE         = 3'd2,
    ST_BEYOND       = 3'd3,
    ST_LIST_FULL    = 3'd4,
    ST_ALREADY_FREE = 3'd5,
    ST_MAP_FULL     = 3'd6
  } fblm_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_HEAD,
    S_HEAD_WAIT,
    S_DONE
  } fblm_state_t;

endpackage

// ----- sv/free_block_list_manager.sv -----
`timescale 1ns / 1ps

// Free block list manager. Each command (release, occupy, extend, check on one block)
// gives one result with a status, the next free block, the free count and the block
// count. The ordered free list lives in a single LIST_DEPTH x 10 memory with one read
// and one write port and registered read data; whether a block is free is found by
// scanning that list, so no per-block map and no clearing pass after reset exist. An
// item that is decided without a scan goes straight to reading the list head; else
// the scan reads one list entry per cycle, and removing a block then moves every
// later entry down by one, again one entry per cycle through the read port. A
// new command is taken only when the previous one has finished; its result may still
// sit in the output register. Writing cfg_wr_data loads the block count (saturated to
// the maximum block count) and empties the list.
module free_block_list_manager #(
  parameter int unsigned LIST_DEPTH = fblm_pkg::FBLM_LIST_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg_wr_data: initial_block_count
  input  logic                            cfg_wr_en,
  input  logic [fblm_pkg::FBLM_TOTAL_W-1:0] cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: [1:0] cmd, [11:2] block, [15:12] zero
  input  logic [fblm_pkg::FBLM_IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [2:0] status, [13:3] next_free, [22:14] free_count,
  //            [33:23] total_blocks, [39:34] zero
  output logic [fblm_pkg::FBLM_OUT_W-1:0] out_tdata
);

  import fblm_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [FBLM_BLK_W-1:0] mem [LIST_DEPTH];
  logic [FBLM_BLK_W-1:0] mem_q_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [FBLM_BLK_W-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  fblm_state_t              state_r, state_nxt;
  fblm_cmd_t                cmd_r, cmd_nxt;
  logic [FBLM_BLK_W-1:0]    blk_r, blk_nxt;
  fblm_status_t             status_r, status_nxt;
  logic [FBLM_TOTAL_W-1:0]  total_r, total_nxt;
  logic [CW-1:0]            entries_r, entries_nxt;
  logic [CW-1:0]            scan_r, scan_nxt;
  logic                     rvld_r, rvld_nxt;
  logic [AW-1:0]            raddr_r, raddr_nxt;
  logic [FBLM_TOTAL_W-1:0]  next_r, next_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [FBLM_OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [FBLM_TOTAL_W-1:0]  in_blk_ext;
  fblm_cmd_t                in_cmd;
  logic                     hit;

  assign in_cmd     = fblm_cmd_t'(in_tdata[1:0]);
  assign in_blk_ext = {1'b0, in_tdata[11:2]};
  assign hit        = rvld_r && (mem_q_r == blk_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      entries_r   <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      entries_r   <= entries_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    blk_r      <= blk_nxt;
    status_r   <= status_nxt;
    scan_r     <= scan_nxt;
    raddr_r    <= raddr_nxt;
    next_r     <= next_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    blk_nxt       = blk_r;
    status_nxt    = status_r;
    total_nxt     = total_r;
    entries_nxt   = entries_r;
    scan_nxt      = scan_r;
    rvld_nxt      = 1'b0;
    raddr_nxt     = raddr_r;
    next_nxt      = next_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = blk_r;
    mem_re        = 1'b0;
    mem_raddr     = scan_r[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_cmd;
          blk_nxt    = in_tdata[11:2];
          status_nxt = ST_OK;
          scan_nxt   = '0;
          state_nxt  = S_SEARCH;
          unique case (in_cmd)
            CMD_RELEASE: begin
              if (in_blk_ext >= total_r || in_blk_ext >= FBLM_MAX_BLOCKS) begin
                status_nxt = ST_BEYOND;
                state_nxt  = S_HEAD;
              end
            end
            CMD_OCCUPY: begin
            end
            CMD_EXTEND: begin
              // a block equal to the count grows the map, then leaves the list
              if (in_blk_ext > total_r) begin
                status_nxt = ST_BEYOND;
                state_nxt  = S_HEAD;
              end else if (in_blk_ext == total_r) begin
                if (total_r >= FBLM_MAX_BLOCKS) begin
                  status_nxt = ST_MAP_FULL;
                  state_nxt  = S_HEAD;
                end else begin
                  total_nxt = total_r + 1'b1;
                end
              end else begin
                state_nxt = S_HEAD;
              end
            end
            CMD_CHECK: begin
              if (in_blk_ext >= total_r) begin
                status_nxt = ST_NO_BLOCK;
                state_nxt  = S_HEAD;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        // compare the entry read last cycle while reading the next one
        if (hit) begin
          unique case (cmd_r)
            CMD_RELEASE: begin
              status_nxt = ST_ALREADY_FREE;
              state_nxt  = S_HEAD;
            end
            CMD_CHECK: begin
              status_nxt = ST_FREE;
              state_nxt  = S_HEAD;
            end
            default: begin
              scan_nxt  = {1'b0, raddr_r} + 1'b1;
              state_nxt = S_SHIFT;
            end
          endcase
        end else if (scan_r < entries_r) begin
          mem_re    = 1'b1;
          mem_raddr = scan_r[AW-1:0];
          raddr_nxt = scan_r[AW-1:0];
          rvld_nxt  = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else begin
          if (cmd_r == CMD_RELEASE) begin
            if (entries_r >= DEPTH_C) begin
              status_nxt = ST_LIST_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = entries_r[AW-1:0];
              mem_wdata   = blk_r;
              entries_nxt = entries_r + 1'b1;
            end
          end
          state_nxt = S_HEAD;
        end
      end

      S_SHIFT: begin
        // move each later entry down by one to close the gap
        if (rvld_r) begin
          mem_we    = 1'b1;
          mem_waddr = raddr_r - 1'b1;
          mem_wdata = mem_q_r;
        end
        if (scan_r < entries_r) begin
          mem_re    = 1'b1;
          mem_raddr = scan_r[AW-1:0];
          raddr_nxt = scan_r[AW-1:0];
          rvld_nxt  = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else if (!rvld_r) begin
          entries_nxt = entries_r - 1'b1;
          state_nxt   = S_HEAD;
        end
      end

      S_HEAD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_HEAD_WAIT;
      end

      S_HEAD_WAIT: begin
        next_nxt  = (entries_r != '0) ? {1'b0, mem_q_r} : total_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, total_r, FBLM_FCNT_W'(entries_r), next_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      total_nxt   = (cfg_wr_data > FBLM_MAX_BLOCKS) ? FBLM_MAX_BLOCKS : cfg_wr_data;
      entries_nxt = '0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) entries_r <= DEPTH_C)
    else $error("free list count exceeds list depth");

  assert property (@(posedge clk) disable iff (!rst_n) total_r <= FBLM_MAX_BLOCKS)
    else $error("block count exceeds maximum");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && rvld_r) |-> (raddr_r != '0))
    else $error("compaction write address underflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && !rvld_r && scan_r >= entries_r) |=> (entries_r != DEPTH_C))
    else $error("list count not reduced after compaction");

endmodule

// ----- dv/fblm_checker.sv -----
`timescale 1ns / 1ps

module fblm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fblm_pkg::FBLM_TOTAL_W-1:0] cfg_wr_data,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [fblm_pkg::FBLM_IN_W-1:0]    in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [fblm_pkg::FBLM_OUT_W-1:0]   out_tdata,
  output int unsigned                       mismatches,
  output int unsigned                       awaited,
  output int unsigned                       compared
);

  import fblm_pkg::*;

  typedef struct packed {
    fblm_status_t             status;
    logic [FBLM_TOTAL_W-1:0]  next_free;
    logic [FBLM_FCNT_W-1:0]   free_count;
    logic [FBLM_TOTAL_W-1:0]  total_blocks;
  } alloc_result_t;

  logic [FBLM_BLK_W-1:0]   free_order [$];
  bit                      free_flag [1024];
  logic [FBLM_TOTAL_W-1:0] block_count;
  alloc_result_t           pending_results [$];

  function automatic void empty_list();
    free_order.delete();
    foreach (free_flag[i]) free_flag[i] = 1'b0;
  endfunction

  // Remove a free block and close the gap behind it.
  function automatic void take_off_list(logic [FBLM_BLK_W-1:0] b);
    int pos = -1;
    if (!free_flag[b]) return;
    foreach (free_order[i]) begin
      if (pos < 0 && free_order[i] == b) pos = i;
    end
    if (pos < 0) return;
    free_order.delete(pos);
    free_flag[b] = 1'b0;
  endfunction

  function automatic alloc_result_t apply_command(fblm_cmd_t c, logic [FBLM_BLK_W-1:0] b);
    alloc_result_t r;
    r.status = ST_OK;
    case (c)
      CMD_RELEASE: begin
        if ({1'b0, b} >= block_count) r.status = ST_BEYOND;
        else if (free_flag[b]) r.status = ST_ALREADY_FREE;
        else if (free_order.size() >= FBLM_LIST_DEPTH) r.status = ST_LIST_FULL;
        else begin
          free_order = {free_order, b};
          free_flag[b] = 1'b1;
        end
      end
      CMD_OCCUPY: take_off_list(b);
      CMD_EXTEND: begin
        if ({1'b0, b} > block_count) r.status = ST_BEYOND;
        else if ({1'b0, b} == block_count) begin
          if (block_count >= FBLM_MAX_BLOCKS) r.status = ST_MAP_FULL;
          else begin
            block_count = block_count + 1'b1;
            take_off_list(b);
          end
        end
      end
      default: begin
        if ({1'b0, b} >= block_count) r.status = ST_NO_BLOCK;
        else if (free_flag[b]) r.status = ST_FREE;
      end
    endcase
    r.next_free    = (free_order.size() > 0) ? {1'b0, free_order[0]} : block_count;
    r.free_count   = FBLM_FCNT_W'(free_order.size());
    r.total_blocks = block_count;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    bit            bad;
    if (!rst_n) begin
      empty_list();
      block_count = '0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        block_count = (cfg_wr_data > FBLM_MAX_BLOCKS) ? FBLM_MAX_BLOCKS : cfg_wr_data;
        empty_list();
      end
      if (in_tvalid && in_tready) begin
        got = apply_command(fblm_cmd_t'(in_tdata[1:0]), in_tdata[11:2]);
        pending_results = {pending_results, got};
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: out_tdata = %h", out_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          bad  = 1'b0;
          if (out_tdata[2:0] != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tdata[2:0]);
            bad = 1'b1;
          end
          if (out_tdata[13:3] != want.next_free) begin
            $error("next_free: expected %0d, actual %0d", want.next_free, out_tdata[13:3]);
            bad = 1'b1;
          end
          if (out_tdata[22:14] != want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count, out_tdata[22:14]);
            bad = 1'b1;
          end
          if (out_tdata[33:23] != want.total_blocks) begin
            $error("total_blocks: expected %0d, actual %0d", want.total_blocks,
                   out_tdata[33:23]);
            bad = 1'b1;
          end
          if (bad) mismatches++;
          compared++;
        end
      end
    end
    awaited = pending_results.size();
  end

endmodule

// ----- dv/free_block_list_manager_tb.sv -----
`timescale 1ns / 1ps

module free_block_list_manager_tb;
  import fblm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          NUM_PHASES  = 7;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [FBLM_TOTAL_W-1:0] cfg_wr_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [FBLM_IN_W-1:0]    in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [FBLM_OUT_W-1:0]   out_tdata;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned compared;

  int unsigned cycles;
  int unsigned sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit [10:0]   size_hint;
  logic [9:0]  released [$];

  int unsigned phase_cfg   [NUM_PHASES] = '{0, 1024, 2047, 1, 300, 1023, 0};
  int unsigned phase_items [NUM_PHASES] = '{200, 450, 200, 150, 250, 200, 200};
  int unsigned phase_rel   [NUM_PHASES] = '{30, 85, 40, 45, 40, 35, 40};

  free_block_list_manager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fblm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaited    (awaited),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Track the block count seen on results to aim extends and releases.
  always @(posedge clk) begin
    if (cfg_wr_en) size_hint <= (cfg_wr_data > FBLM_MAX_BLOCKS) ? FBLM_MAX_BLOCKS : cfg_wr_data;
    else if (out_tvalid && out_tready) size_hint <= out_tdata[33:23];
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send(input fblm_cmd_t c, input logic [9:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, b, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(input logic [10:0] value);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    released.delete();
  endtask

  function automatic logic [9:0] pick_block();
    int lim;
    int r;
    int v;
    lim = (size_hint == 0) ? 1 : int'(size_hint);
    r   = $urandom_range(99);
    if (r < 80) v = $urandom_range(lim - 1);
    else if (r < 90) v = $urandom_range(1023);
    else v = lim - 1 + $urandom_range(2);
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  function automatic logic [9:0] pool_or_pick();
    if (released.size() > 0 && $urandom_range(9) < 7)
      return released[$urandom_range(released.size() - 1)];
    return pick_block();
  endfunction

  function automatic void next_command(input int unsigned rel_pct,
                                       output fblm_cmd_t c, output logic [9:0] b);
    int s;
    int t;
    int v;
    if ($urandom_range(99) < rel_pct) begin
      c = CMD_RELEASE;
      b = pick_block();
      released = {released, b};
      if (released.size() > 300) void'(released.pop_front());
    end else begin
      s = $urandom_range(99);
      if (s < 40) begin
        c = CMD_OCCUPY;
        b = pool_or_pick();
      end else if (s < 65) begin
        c = CMD_EXTEND;
        t = $urandom_range(9);
        if (t < 6) v = size_hint;
        else if (t < 8) v = (size_hint == 0) ? 0 : $urandom_range(size_hint - 1);
        else v = size_hint + 1 + $urandom_range(2);
        if (v > 1023) v = 1023;
        b = v[9:0];
      end else begin
        c = CMD_CHECK;
        b = ($urandom_range(1) == 0) ? pool_or_pick() : pick_block();
      end
    end
  endfunction

  initial begin
    fblm_cmd_t  c;
    logic [9:0] b;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    send_idle_pct = 14;
    recv_idle_pct = 81;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Block count zero out of reset.
    send(CMD_CHECK, 10'd0);
    send(CMD_RELEASE, 10'd0);
    send(CMD_EXTEND, 10'd1);
    send(CMD_EXTEND, 10'd0);
    send(CMD_RELEASE, 10'd0);
    send(CMD_RELEASE, 10'd0);
    send(CMD_CHECK, 10'd0);
    send(CMD_EXTEND, 10'd0);
    send(CMD_OCCUPY, 10'd5);
    send(CMD_OCCUPY, 10'd0);
    send(CMD_CHECK, 10'd0);
    send(CMD_RELEASE, 10'd1023);

    // Full-size map: head, middle and tail removal.
    write_count(11'd1024);
    send(CMD_RELEASE, 10'd1023);
    send(CMD_RELEASE, 10'd0);
    send(CMD_RELEASE, 10'd512);
    send(CMD_OCCUPY, 10'd0);
    send(CMD_CHECK, 10'd1023);
    send(CMD_EXTEND, 10'd1023);
    send(CMD_RELEASE, 10'd700);
    send(CMD_OCCUPY, 10'd512);
    send(CMD_OCCUPY, 10'd700);
    send(CMD_CHECK, 10'd1023);
    send(CMD_OCCUPY, 10'd1023);
    send(CMD_CHECK, 10'd1023);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 81;
      end else if (p < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_count((p == NUM_PHASES - 1) ? 11'($urandom_range(2047)) : 11'(phase_cfg[p]));
      repeat (phase_items[p]) begin
        next_command(phase_rel[p], c, b);
        send(c, b);
      end
    end

    drain();
    repeat (FBLM_LIST_DEPTH + 20) @(negedge clk);

    $display("Ran %0d commands over %0d block-count settings; %0d results compared in order.",
             sent, NUM_PHASES + 2, compared);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- free_block_list_manager.f -----
sv/fblm_pkg.sv
sv/free_block_list_manager.sv
dv/fblm_checker.sv
dv/free_block_list_manager_tb.sv
